[hw/rtl/bev_pkg.sv]
// Shared types and character codes for the bracket expression validator.
// Used by bev_classify, bev_stack and bracket_expression_validator.
package bev_pkg;

   typedef enum logic [1:0] {
      BR_ROUND  = 2'd0,
      BR_CURLY  = 2'd1,
      BR_SQUARE = 2'd2,
      BR_NONE   = 2'd3
   } bracket_type;

   typedef struct packed {
      logic        is_open;
      logic        is_close;
      logic        allowed;
      bracket_type kind;
   } char_class_type;

   typedef struct packed {
      logic expr_ok;
      logic depth_overflow;
   } result_type;

   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LCURLY  = 8'h7B;
   localparam logic [7:0] CH_RCURLY  = 8'h7D;
   localparam logic [7:0] CH_LSQUARE = 8'h5B;
   localparam logic [7:0] CH_RSQUARE = 8'h5D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

endpackage

[hw/rtl/bev_classify.sv]
// Character decoder: opener, closer, plain allowed character, bracket kind.
// Depends on bev_pkg.
module bev_classify (
   input  logic [7:0]              char_code,
   output bev_pkg::char_class_type char_class
);

   logic is_digit;
   logic is_plain;

   assign is_digit = (char_code >= bev_pkg::CH_ZERO) && (char_code <= bev_pkg::CH_NINE);
   assign is_plain = is_digit || (char_code == bev_pkg::CH_SPACE)
                  || (char_code == bev_pkg::CH_PLUS) || (char_code == bev_pkg::CH_MINUS)
                  || (char_code == bev_pkg::CH_SLASH) || (char_code == bev_pkg::CH_STAR);

   always_comb begin
      char_class.is_open  = 1'b0;
      char_class.is_close = 1'b0;
      char_class.allowed  = is_plain;
      char_class.kind     = bev_pkg::BR_NONE;
      unique case (char_code)
         bev_pkg::CH_LPAREN: begin
            char_class.is_open = 1'b1;
            char_class.kind    = bev_pkg::BR_ROUND;
         end
         bev_pkg::CH_LCURLY: begin
            char_class.is_open = 1'b1;
            char_class.kind    = bev_pkg::BR_CURLY;
         end
         bev_pkg::CH_LSQUARE: begin
            char_class.is_open = 1'b1;
            char_class.kind    = bev_pkg::BR_SQUARE;
         end
         bev_pkg::CH_RPAREN: begin
            char_class.is_close = 1'b1;
            char_class.kind     = bev_pkg::BR_ROUND;
         end
         bev_pkg::CH_RCURLY: begin
            char_class.is_close = 1'b1;
            char_class.kind     = bev_pkg::BR_CURLY;
         end
         bev_pkg::CH_RSQUARE: begin
            char_class.is_close = 1'b1;
            char_class.kind     = bev_pkg::BR_SQUARE;
         end
         default: begin
         end
      endcase
   end

endmodule

[hw/rtl/bev_stack.sv]
// Bracket stack with top-of-stack register, level counter and error flags.
// Depends on bev_pkg; the stack memory lives here.
module bev_stack #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   beat,
   input  logic                   last_char,
   input  bev_pkg::char_class_type char_class,
   output bev_pkg::result_type    result
);

   localparam int LVL_W = $clog2(STACK_DEPTH + 1);
   localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [LVL_W-1:0] FULL_LEVEL = LVL_W'(STACK_DEPTH);

   bev_pkg::bracket_type stack_mem [STACK_DEPTH];

   logic [LVL_W-1:0]     level_ff, level_in, level_upd;
   logic                 error_ff, error_in, error_upd;
   logic                 overflow_ff, overflow_in, overflow_upd;
   bev_pkg::bracket_type top_ff;
   logic                 push;
   logic                 pop;
   logic [PTR_W-1:0]     wr_addr;
   logic [PTR_W-1:0]     rd_addr;

   always_comb begin
      push         = 1'b0;
      pop          = 1'b0;
      error_upd    = error_ff;
      overflow_upd = overflow_ff;
      if (char_class.is_open) begin
         if (level_ff == FULL_LEVEL) begin
            error_upd    = 1'b1;
            overflow_upd = 1'b1;
         end else begin
            push = 1'b1;
         end
      end else if (char_class.is_close) begin
         if ((level_ff == '0) || (top_ff != char_class.kind)) begin
            error_upd = 1'b1;
         end else begin
            pop = 1'b1;
         end
      end else if (!char_class.allowed) begin
         error_upd = 1'b1;
      end
      level_upd = push ? level_ff + 1'b1 : (pop ? level_ff - 1'b1 : level_ff);
   end

   assign result.expr_ok        = !error_upd && !overflow_upd && (level_upd == '0);
   assign result.depth_overflow = overflow_upd;

   always_comb begin
      level_in    = level_ff;
      error_in    = error_ff;
      overflow_in = overflow_ff;
      if (beat) begin
         if (last_char) begin
            level_in    = '0;
            error_in    = 1'b0;
            overflow_in = 1'b0;
         end else begin
            level_in    = level_upd;
            error_in    = error_upd;
            overflow_in = overflow_upd;
         end
      end
   end

   assign wr_addr = level_ff[PTR_W-1:0];
   assign rd_addr = PTR_W'(level_upd - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= '0;
         error_ff    <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         level_ff    <= level_in;
         error_ff    <= error_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat && push) begin
         stack_mem[wr_addr] <= char_class.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (beat) begin
         if (push) begin
            top_ff <= char_class.kind;
         end else begin
            top_ff <= stack_mem[rd_addr];
         end
      end
   end

endmodule

[hw/rtl/bracket_expression_validator.sv]
// Bracket expression validator: one character per beat, one result per expression.
// Depends on bev_pkg, bev_classify and bev_stack.
//
// Usage:
//   The req channel carries one ASCII character per beat (req_char_code) and
//   req_last_char marks the final character of an expression. A beat is taken
//   when req_valid is high and req_stall is low.
//   The rsp channel carries one result per expression: rsp_expr_ok is 1 when
//   all characters are digits, space, + - / * or brackets and the brackets nest
//   and match; rsp_depth_overflow is 1 when nesting went past STACK_DEPTH.
//   A result beat is taken when rsp_valid is high and rsp_stall is low.
//   Throughput: one character per cycle while req_stall is low; the stack push or pop and the top of
//   stack compare finish in the cycle the character is taken.
//   Result: the result is registered and appears in the cycle after the last character is taken.
//   Stall: while a result waits, characters that are not last are still taken;
//   a last character is held off until the waiting result is taken.
//   Reset clears the level counter, the error flags and the result valid flag;
//   the stack memory is not cleared and needs no clearing pass.
module bracket_expression_validator #(
   parameter int STACK_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_expr_ok,
   output logic       rsp_depth_overflow
);

   bev_pkg::char_class_type char_class;
   bev_pkg::result_type     result;
   logic                    req_beat;
   logic                    last_beat;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    expr_ok_ff;
   logic                    depth_overflow_ff;

   assign req_stall = rsp_valid_ff && rsp_stall && req_last_char;
   assign req_beat  = req_valid && !req_stall;
   assign last_beat = req_beat && req_last_char;

   bev_classify u_classify (
      .char_code  (req_char_code),
      .char_class (char_class)
   );

   bev_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .beat       (req_beat),
      .last_char  (req_last_char),
      .char_class (char_class),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (last_beat) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_beat) begin
         expr_ok_ff        <= result.expr_ok;
         depth_overflow_ff <= result.depth_overflow;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_expr_ok        = expr_ok_ff;
   assign rsp_depth_overflow = depth_overflow_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_expr_ok && rsp_depth_overflow))
      else $error("overflow reported on a valid expression");

   assert property (@(posedge clock) disable iff (reset)
      last_beat |=> rsp_valid)
      else $error("last character taken without a result");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !last_beat) |=> !rsp_valid)
      else $error("result raised without a last character");

endmodule
